// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file of the duty cycle generator.
// Each macro expands to one labeled concurrent assertion that reports with $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SDC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define SDC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ===== rtl/core/sdc_pkg.sv =====
// Package of the sine PWM duty cycle generator: stage counts, sine polynomial
// coefficients, register indexes and output scaling constants. No dependencies.
`default_nettype none

package sdc_pkg;

   localparam int FREQ_W     = 24;
   localparam int INDEX_W    = 16;
   localparam int TIME_W     = 32;
   localparam int DUTY_W     = 17;
   localparam int FRAC_BITS  = 28;
   localparam int Q30        = 30;
   localparam int ANGLE_W    = 31;
   localparam int COEF_W     = 31;
   localparam int MAG_W      = 18;
   localparam int RAW_W      = 19;

   localparam int PH_STAGES  = 2;
   localparam int SIN_STAGES = 7;
   localparam int SCL_STAGES = 2;
   localparam int STAGES     = PH_STAGES + SIN_STAGES + SCL_STAGES;
   localparam int HORNER_STEPS = 4;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 24;
   localparam logic [CSR_IDX_W-1:0] CSR_MOD_FREQUENCY = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MOD_INDEX     = 1'b1;

   localparam logic [FREQ_W-1:0]  FREQ_RESET  = 24'd12800;
   localparam logic [INDEX_W-1:0] INDEX_RESET = 16'd13107;

   localparam logic [COEF_W-1:0] C1 = 31'd1686629713;
   localparam logic [COEF_W-1:0] C3 = 31'd693598665;
   localparam logic [COEF_W-1:0] C5 = 31'd85569306;
   localparam logic [COEF_W-1:0] C7 = 31'd5026995;
   localparam logic [COEF_W-1:0] C9 = 31'd172273;

   localparam logic signed [32:0] HALF_TURN    = 33'sd2147483648;
   localparam logic signed [32:0] QUARTER_TURN = 33'sd1073741824;

   localparam logic signed [RAW_W-1:0] DUTY_MID  = 19'sd32768;
   localparam logic signed [RAW_W-1:0] DUTY_FULL = 19'sd65536;

   typedef logic [SIN_STAGES-1:0] sin_en_type;
   typedef logic [SCL_STAGES-1:0] scl_en_type;
   typedef logic [PH_STAGES-1:0]  ph_en_type;

   function automatic logic [COEF_W-1:0] horner_coef(input logic [1:0] step);
      logic [COEF_W-1:0] c;
      case (step)
         2'd0:    c = C7;
         2'd1:    c = C5;
         2'd2:    c = C3;
         2'd3:    c = C1;
         default: c = C1;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/spwm_duty_cycle_top.sv =====
// Throughput: one request per cycle unless rsp_stall holds the pipeline; the eleven-stage
// pipeline holds one item per stage and an empty stage is filled even while the output
// stage is stalled.
// Reset clears all stage valid bits and loads mod_frequency 12800 and mod_index 13107.
// Top level of the sine PWM duty cycle generator; uses sdc_pkg, sdc_phase,
// sdc_sine and sdc_scale.
`default_nettype none

module spwm_duty_cycle_top #(
   parameter int PHASE_BITS = 16,
   parameter int SINE_BITS  = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [sdc_pkg::TIME_W-1:0]         req_time_stamp,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [sdc_pkg::DUTY_W-1:0]         rsp_duty_cycle,
   output logic                               rsp_clamped,
   input  logic                               csr_write,
   input  logic [sdc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sdc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int NS = sdc_pkg::STAGES;
   localparam int PS = sdc_pkg::PH_STAGES;
   localparam int SS = sdc_pkg::SIN_STAGES;

   logic [sdc_pkg::FREQ_W-1:0]   freq_ff;
   logic [sdc_pkg::INDEX_W-1:0]  index_ff;
   logic [NS-1:0]                vld_ff;
   logic [NS-1:0]                vld_in;
   logic [NS-1:0]                rdy;
   logic [sdc_pkg::ANGLE_W-1:0]  angle;
   logic                         angle_neg;
   logic [SINE_BITS-2:0]         sine_mag;
   logic                         sine_neg;

   always_ff @(posedge clock) begin
      if (reset) begin
         freq_ff  <= sdc_pkg::FREQ_RESET;
         index_ff <= sdc_pkg::INDEX_RESET;
      end else if (csr_write) begin
         case (csr_index)
            sdc_pkg::CSR_MOD_FREQUENCY: freq_ff  <= csr_wdata[sdc_pkg::FREQ_W-1:0];
            sdc_pkg::CSR_MOD_INDEX:     index_ff <= csr_wdata[sdc_pkg::INDEX_W-1:0];
            default: ;
         endcase
      end
   end

   // A stage may load when it is empty or when the stage after it moves on.
   always_comb begin
      rdy[NS-1] = !vld_ff[NS-1] || !rsp_stall;
      for (int k = NS - 2; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
      vld_in[0] = rdy[0] ? req_valid : vld_ff[0];
      for (int k = 1; k < NS; k++) begin
         vld_in[k] = rdy[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   sdc_phase #(
      .PHASE_BITS (PHASE_BITS)
   ) u_phase (
      .clock         (clock),
      .en            (rdy[PS-1:0]),
      .mod_frequency (freq_ff),
      .time_stamp    (req_time_stamp),
      .angle         (angle),
      .angle_neg     (angle_neg)
   );

   sdc_sine #(
      .SINE_BITS (SINE_BITS)
   ) u_sine (
      .clock     (clock),
      .en        (rdy[PS+SS-1:PS]),
      .angle     (angle),
      .angle_neg (angle_neg),
      .sine_mag  (sine_mag),
      .sine_neg  (sine_neg)
   );

   sdc_scale #(
      .SINE_BITS (SINE_BITS)
   ) u_scale (
      .clock      (clock),
      .en         (rdy[NS-1:PS+SS]),
      .mod_index  (index_ff),
      .sine_mag   (sine_mag),
      .sine_neg   (sine_neg),
      .duty_cycle (rsp_duty_cycle),
      .clamped    (rsp_clamped)
   );

   assign req_stall = !rdy[0];
   assign rsp_valid = vld_ff[NS-1];

endmodule

`default_nettype wire

// ===== rtl/core/sdc_phase.sv =====
// Phase front end: frequency times time stamp, fraction of a turn, and the fold
// into a quarter-turn angle with its sign. Depends on sdc_pkg.
`default_nettype none

module sdc_phase #(
   parameter int PHASE_BITS = 16
) (
   input  logic                            clock,
   input  sdc_pkg::ph_en_type              en,
   input  logic [sdc_pkg::FREQ_W-1:0]      mod_frequency,
   input  logic [sdc_pkg::TIME_W-1:0]      time_stamp,
   output logic [sdc_pkg::ANGLE_W-1:0]     angle,
   output logic                            angle_neg
);

   localparam int PROD_W = sdc_pkg::FREQ_W + sdc_pkg::FRAC_BITS;

   logic [PROD_W-1:0]                prod;
   logic [PHASE_BITS-1:0]            phase_ff;
   logic [31:0]                      p32;
   logic signed [32:0]               a;
   logic signed [32:0]               folded;
   logic signed [32:0]               folded_abs;
   logic [sdc_pkg::ANGLE_W-1:0]      angle_ff;
   logic                             neg_ff;

   assign prod = {{sdc_pkg::FRAC_BITS{1'b0}}, mod_frequency}
               * {{sdc_pkg::FREQ_W{1'b0}}, time_stamp[sdc_pkg::FRAC_BITS-1:0]};

   always_ff @(posedge clock) begin
      if (en[0]) begin
         phase_ff <= prod[sdc_pkg::FRAC_BITS-1 -: PHASE_BITS];
      end
   end

   always_comb begin
      p32 = {phase_ff, {(32-PHASE_BITS){1'b0}}};
      a   = signed'({p32[31], p32});
      if (a > sdc_pkg::QUARTER_TURN) begin
         folded = sdc_pkg::HALF_TURN - a;
      end else if (a < -sdc_pkg::QUARTER_TURN) begin
         folded = -sdc_pkg::HALF_TURN - a;
      end else begin
         folded = a;
      end
      folded_abs = folded[32] ? -folded : folded;
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         angle_ff <= folded_abs[sdc_pkg::ANGLE_W-1:0];
         neg_ff   <= folded[32];
      end
   end

   assign angle     = angle_ff;
   assign angle_neg = neg_ff;

endmodule

`default_nettype wire

// ===== rtl/core/sdc_sine.sv =====
// Sine evaluation: square of the angle, four Horner steps of the odd polynomial,
// final product and rounding to a sample magnitude. Depends on sdc_pkg.
`default_nettype none

module sdc_sine #(
   parameter int SINE_BITS = 16
) (
   input  logic                            clock,
   input  sdc_pkg::sin_en_type             en,
   input  logic [sdc_pkg::ANGLE_W-1:0]     angle,
   input  logic                            angle_neg,
   output logic [SINE_BITS-2:0]            sine_mag,
   output logic                            sine_neg
);

   localparam int AW = sdc_pkg::ANGLE_W;
   localparam int CW = sdc_pkg::COEF_W;
   localparam int NH = sdc_pkg::HORNER_STEPS;
   localparam int SH = 31 - SINE_BITS;
   localparam logic [31:0] ROUND_HALF = 32'd1 << (SH - 1);
   localparam logic [31:0] SINE_LIM   = (32'd1 << (SINE_BITS - 1)) - 32'd1;

   logic [AW-1:0]        x_ff   [0:NH];
   logic                 neg_ff [0:NH];
   logic [AW-1:0]        x2_ff  [0:NH-1];
   logic [CW-1:0]        t_ff   [0:NH-1];
   logic [CW-1:0]        t_src  [0:NH-1];
   logic [2*AW-1:0]      sq;
   logic [2*AW-1:0]      fin;
   logic [31:0]          s_ff;
   logic                 s_neg_ff;
   logic [31:0]          rounded;
   logic [31:0]          shifted;
   logic [SINE_BITS-2:0] mag_ff;
   logic                 mag_neg_ff;

   assign sq = {{AW{1'b0}}, angle} * {{AW{1'b0}}, angle};

   always_ff @(posedge clock) begin
      if (en[0]) begin
         x_ff[0]   <= angle;
         neg_ff[0] <= angle_neg;
         x2_ff[0]  <= sq[sdc_pkg::Q30 +: AW];
      end
   end

   genvar j;
   generate
      for (j = 0; j < NH; j++) begin : g_horner
         logic [2*CW-1:0] hp;

         if (j == 0) begin : g_first
            assign t_src[j] = sdc_pkg::C9;
         end else begin : g_next
            assign t_src[j] = t_ff[j-1];
         end

         assign hp = {{CW{1'b0}}, x2_ff[j]} * {{AW{1'b0}}, t_src[j]};

         always_ff @(posedge clock) begin
            if (en[j+1]) begin
               t_ff[j]     <= sdc_pkg::horner_coef(2'(j)) - hp[sdc_pkg::Q30 +: CW];
               x_ff[j+1]   <= x_ff[j];
               neg_ff[j+1] <= neg_ff[j];
            end
         end

         if (j < NH - 1) begin : g_pass
            always_ff @(posedge clock) begin
               if (en[j+1]) begin
                  x2_ff[j+1] <= x2_ff[j];
               end
            end
         end
      end
   endgenerate

   assign fin = {{CW{1'b0}}, x_ff[NH]} * {{AW{1'b0}}, t_ff[NH-1]};

   always_ff @(posedge clock) begin
      if (en[NH+1]) begin
         s_ff     <= fin[sdc_pkg::Q30 +: 32];
         s_neg_ff <= neg_ff[NH];
      end
   end

   always_comb begin
      rounded = s_ff + ROUND_HALF;
      shifted = rounded >> SH;
      if (shifted > SINE_LIM) begin
         shifted = SINE_LIM;
      end
   end

   always_ff @(posedge clock) begin
      if (en[NH+2]) begin
         mag_ff     <= shifted[SINE_BITS-2:0];
         mag_neg_ff <= s_neg_ff;
      end
   end

   assign sine_mag = mag_ff;
   assign sine_neg = mag_neg_ff;

endmodule

`default_nettype wire

// ===== rtl/core/sdc_scale.sv =====
// Output stage: scales the sine sample by the modulation index, rounds, centers
// on one half and saturates to the Q1.16 duty range. Depends on sdc_pkg.
`default_nettype none

module sdc_scale #(
   parameter int SINE_BITS = 16
) (
   input  logic                            clock,
   input  sdc_pkg::scl_en_type             en,
   input  logic [sdc_pkg::INDEX_W-1:0]     mod_index,
   input  logic [SINE_BITS-2:0]            sine_mag,
   input  logic                            sine_neg,
   output logic [sdc_pkg::DUTY_W-1:0]      duty_cycle,
   output logic                            clamped
);

   localparam int PW = sdc_pkg::INDEX_W + SINE_BITS - 1;
   localparam int RW = sdc_pkg::RAW_W;
   localparam logic [PW:0] ROUND_HALF = (PW+1)'(1) << (SINE_BITS - 3);

   logic [PW-1:0]                  prod_ff;
   logic                           neg_ff;
   logic [PW:0]                    sum;
   logic [sdc_pkg::MAG_W-1:0]      mag;
   logic signed [RW-1:0]           raw;
   logic [sdc_pkg::DUTY_W-1:0]     duty_in;
   logic                           clamped_in;
   logic [sdc_pkg::DUTY_W-1:0]     duty_ff;
   logic                           clamped_ff;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         prod_ff <= PW'(mod_index * sine_mag);
         neg_ff  <= sine_neg;
      end
   end

   always_comb begin
      sum = {1'b0, prod_ff} + ROUND_HALF;
      mag = sum[PW -: sdc_pkg::MAG_W];
      if (neg_ff) begin
         raw = sdc_pkg::DUTY_MID - signed'({1'b0, mag});
      end else begin
         raw = sdc_pkg::DUTY_MID + signed'({1'b0, mag});
      end
      if (raw < 0) begin
         duty_in    = '0;
         clamped_in = 1'b1;
      end else if (raw > sdc_pkg::DUTY_FULL) begin
         duty_in    = sdc_pkg::DUTY_FULL[sdc_pkg::DUTY_W-1:0];
         clamped_in = 1'b1;
      end else begin
         duty_in    = raw[sdc_pkg::DUTY_W-1:0];
         clamped_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         duty_ff    <= duty_in;
         clamped_ff <= clamped_in;
      end
   end

   assign duty_cycle = duty_ff;
   assign clamped    = clamped_ff;

endmodule

`default_nettype wire

// ===== rtl/core/sdc_checker.sv =====
// Port-level checker of the sine PWM duty cycle generator, bound to its top level.
// Depends on assert_macros.svh and sdc_pkg.
`default_nettype none
`include "assert_macros.svh"

module sdc_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_stall,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic [sdc_pkg::DUTY_W-1:0]   rsp_duty_cycle,
   input  logic                         rsp_clamped
);

   localparam logic [sdc_pkg::DUTY_W-1:0] FULL = 17'd65536;

   logic                        at_rail;
   logic                        rsp_wait;
   logic [sdc_pkg::DUTY_W:0]    rsp_data;

   assign at_rail  = (rsp_duty_cycle == '0) || (rsp_duty_cycle == FULL);
   assign rsp_wait = rsp_valid && rsp_stall;
   assign rsp_data = {rsp_duty_cycle, rsp_clamped};

   `SDC_ASSERT_NOW(a_duty_range, clock, reset, rsp_valid, rsp_duty_cycle <= FULL)
   `SDC_ASSERT_NOW(a_clamp_rail, clock, reset, rsp_valid && rsp_clamped, at_rail)
   `SDC_ASSERT_NOW(a_stall_cause, clock, reset, req_stall, rsp_wait)
   `SDC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_wait, rsp_valid && $stable(rsp_data))

endmodule

bind spwm_duty_cycle_top sdc_checker u_sdc_checker (.*);

`default_nettype wire

// ===== sim/tb_spwm_duty_cycle_top.sv =====
// Self-checking testbench for spwm_duty_cycle_top: an in-bench predictor computes the
// duty cycle of every accepted request and a monitor compares each result in order.
// Depends on sdc_pkg and the spwm_duty_cycle_top RTL.
`timescale 1ns / 1ps

module tb_spwm_duty_cycle_top;

   typedef struct packed {
      logic [16:0] duty;
      logic        clamped;
   } duty_result_type;

   localparam logic [63:0] SIN_K1 = 64'd1686629713;
   localparam logic [63:0] SIN_K3 = 64'd693598665;
   localparam logic [63:0] SIN_K5 = 64'd85569306;
   localparam logic [63:0] SIN_K7 = 64'd5026995;
   localparam logic [63:0] SIN_K9 = 64'd172273;
   localparam longint TURN_HALF    = 64'sd2147483648;
   localparam longint TURN_QUARTER = 64'sd1073741824;
   localparam longint DUTY_CENTER  = 64'sd32768;
   localparam longint DUTY_TOP     = 64'sd65536;
   localparam int     DRAIN_CYCLES = sdc_pkg::STAGES + 4;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [31:0] req_time_stamp;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [16:0] rsp_duty_cycle;
   logic        rsp_clamped;
   logic        csr_write;
   logic [sdc_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [sdc_pkg::CSR_DATA_W-1:0] csr_wdata;

   logic [23:0]     freq_setting;
   logic [15:0]     index_setting;
   duty_result_type pending_duty[$];
   int              error_count;
   int              send_idle_pct;
   int              recv_idle_pct;
   int              hold_request;
   int              hold_left;

   spwm_duty_cycle_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_time_stamp (req_time_stamp),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_duty_cycle (rsp_duty_cycle),
      .rsp_clamped    (rsp_clamped),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic longint sine_sample_q15(input logic [15:0] phase);
      longint      angle;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      bit          neg;
      angle = longint'({32'd0, phase, 16'd0});
      if (angle >= TURN_HALF)
         angle = angle - 2 * TURN_HALF;
      if (angle > TURN_QUARTER)
         angle = TURN_HALF - angle;
      else if (angle < -TURN_QUARTER)
         angle = -TURN_HALF - angle;
      neg = angle < 0;
      x = neg ? 64'(-angle) : 64'(angle);
      x2 = (x * x) >> 30;
      t = SIN_K9;
      t = SIN_K7 - ((x2 * t) >> 30);
      t = SIN_K5 - ((x2 * t) >> 30);
      t = SIN_K3 - ((x2 * t) >> 30);
      t = SIN_K1 - ((x2 * t) >> 30);
      s = (x * t) >> 30;
      s = (s + 64'd16384) >> 15;
      if (s > 64'd32767)
         s = 64'd32767;
      return neg ? -longint'(s) : longint'(s);
   endfunction

   function automatic duty_result_type predict_duty(input logic [31:0] stamp);
      logic [63:0]     prod;
      longint          sine;
      logic [63:0]     mag;
      longint          raw;
      duty_result_type r;
      prod = {32'd0, stamp} * {40'd0, freq_setting};
      sine = sine_sample_q15(prod[27:12]);
      mag = ({48'd0, index_setting} * 64'(sine < 0 ? -sine : sine) + 64'd8192) >> 14;
      raw = (sine < 0) ? DUTY_CENTER - longint'(mag) : DUTY_CENTER + longint'(mag);
      if (raw < 0) begin
         r.duty = 17'd0;
         r.clamped = 1'b1;
      end else if (raw > DUTY_TOP) begin
         r.duty = 17'd65536;
         r.clamped = 1'b1;
      end else begin
         r.duty = 17'(raw);
         r.clamped = 1'b0;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      duty_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_duty.size() == 0) begin
            $display("%0t: unexpected result duty %0d clamped %0d",
                     $time, rsp_duty_cycle, rsp_clamped);
            error_count++;
         end else begin
            want = pending_duty.pop_front();
            if (rsp_duty_cycle !== want.duty) begin
               $display("%0t: duty_cycle expected %0d actual %0d",
                        $time, want.duty, rsp_duty_cycle);
               error_count++;
            end
            if (rsp_clamped !== want.clamped) begin
               $display("%0t: clamped expected %0d actual %0d",
                        $time, want.clamped, rsp_clamped);
               error_count++;
            end
         end
      end
   end

   task automatic send_request(input logic [31:0] stamp);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_time_stamp <= stamp;
      do @(posedge clock); while (req_stall);
      pending_duty.push_back(predict_duty(stamp));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_duty.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(input logic [23:0] freq, input logic [15:0] index);
      wait_idle();
      csr_write <= 1'b1;
      csr_index <= sdc_pkg::CSR_MOD_FREQUENCY;
      csr_wdata <= freq;
      @(posedge clock);
      csr_index <= sdc_pkg::CSR_MOD_INDEX;
      csr_wdata <= {8'd0, index};
      @(posedge clock);
      csr_write <= 1'b0;
      freq_setting = freq;
      index_setting = index;
   endtask

   task automatic test_reset_config();
      send_request(32'h0000_0000);
      send_request(32'hFFFF_FFFF);
      send_request(32'h0001_0000);
   endtask

   task automatic test_phase_points();
      set_config(24'd1, 16'd16384);
      send_request(32'h0000_0000);
      send_request(32'h0400_0000);
      send_request(32'h0400_1000);
      send_request(32'h0800_0000);
      send_request(32'h0C00_0000);
      send_request(32'h0FFF_F000);
      send_request(32'h1000_0000);
      send_request(32'h0000_0FFF);
   endtask

   task automatic test_over_modulation();
      set_config(24'd1, 16'd32768);
      send_request(32'h0400_0000);
      send_request(32'h0C00_0000);
      send_request(32'h0200_0000);
      set_config(24'hFF_FFFF, 16'hFFFF);
      send_request(32'h0000_0001);
      send_request(32'h0000_1000);
      send_request(32'h8000_0000);
      send_request(32'hFFFF_FFFF);
   endtask

   task automatic test_zero_cases();
      set_config(24'd0, 16'hFFFF);
      send_request(32'hFFFF_FFFF);
      send_request(32'h0400_0000);
      set_config(24'd1, 16'd0);
      send_request(32'h0400_0000);
   endtask

   task automatic test_random_sweep(input int sender_pct, input int receiver_pct);
      logic [23:0] freq;
      logic [15:0] index;
      logic [31:0] stamp;
      send_idle_pct = sender_pct;
      recv_idle_pct = receiver_pct;
      for (int k = 0; k < 4; k++) begin
         case ($urandom_range(4))
            0: freq = 24'($urandom_range(24'hFF_FFFF));
            1: freq = 24'($urandom_range(1, 4096));
            2: freq = 24'($urandom_range(12000, 13600));
            3: freq = 24'hFF_FFFF;
            default: freq = 24'($urandom_range(1, 255));
         endcase
         case ($urandom_range(3))
            0: index = 16'($urandom_range(16'hFFFF));
            1: index = 16'd16384;
            2: index = 16'($urandom_range(14000, 24000));
            default: index = 16'hFFFF;
         endcase
         set_config(freq, index);
         for (int n = 0; n < 85; n++) begin
            stamp = $urandom;
            if ($urandom_range(7) == 0)
               stamp = stamp & 32'h000F_FFFF;
            send_request(stamp);
         end
      end
   endtask

   task automatic test_back_pressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_config(24'($urandom_range(1, 24'hFF_FFFF)), 16'($urandom_range(16'hFFFF)));
      hold_request = 80;
      for (int n = 0; n < 40; n++)
         send_request($urandom);
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_time_stamp = 32'd0;
      csr_write = 1'b0;
      csr_index = sdc_pkg::CSR_MOD_FREQUENCY;
      csr_wdata = '0;
      rsp_stall = 1'b0;
      error_count = 0;
      hold_request = 0;
      hold_left = 0;
      freq_setting = 24'd12800;
      index_setting = 16'd13107;
      send_idle_pct = 27;
      recv_idle_pct = 62;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_config();
      test_phase_points();
      test_over_modulation();
      test_zero_cases();
      test_random_sweep(27, 62);
      test_random_sweep(62, 27);
      test_random_sweep(0, 0);
      test_back_pressure();
      wait_idle();

      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Some tests failed");
      $finish;
   end

endmodule
